// ===== hw/rtl/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register map, reset values and the request types that
// travel between the stages of the perspective point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int COORD_W   = 32;
    localparam int VIEW_W    = 34;
    localparam int FOCAL_W   = 12;
    localparam int PROD_W    = 46;
    localparam int MAG_W     = 45;
    localparam int DEPTH_W   = 33;
    localparam int PIX_W     = 10;
    localparam int ADDR_W    = 19;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = 40;

    localparam int DEF_SCREEN_WIDTH  = 800;
    localparam int DEF_SCREEN_HEIGHT = 600;
    localparam int DEF_QUOT_W =
        $clog2((DEF_SCREEN_WIDTH > DEF_SCREEN_HEIGHT) ? DEF_SCREEN_WIDTH
                                                      : DEF_SCREEN_HEIGHT) + 1;

    typedef enum logic [2:0] {
        REG_MODEL_X,
        REG_MODEL_Y,
        REG_MODEL_Z,
        REG_CAMERA_X,
        REG_CAMERA_Y,
        REG_CAMERA_Z,
        REG_FOCAL
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] model_x;
        logic signed [COORD_W-1:0] model_y;
        logic signed [COORD_W-1:0] model_z;
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic signed [COORD_W-1:0] camera_z;
        logic        [FOCAL_W-1:0] focal;
    } cfg_t;

    localparam logic signed [COORD_W-1:0] DEPTH_RESET = 32'shFFF6_0000;
    localparam logic        [FOCAL_W-1:0] FOCAL_RESET = 12'd900;

    localparam cfg_t CFG_RESET = '{
        model_x:  '0,
        model_y:  '0,
        model_z:  DEPTH_RESET,
        camera_x: '0,
        camera_y: '0,
        camera_z: DEPTH_RESET,
        focal:    FOCAL_RESET
    };

    typedef struct packed {
        logic last;
        logic zpos;
        logic sign_x;
        logic sign_y;
        logic ovf_x;
        logic ovf_y;
    } flags_t;

    typedef struct packed {
        flags_t             flags;
        logic [DEPTH_W-1:0] depth;
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
    } div_req_t;

endpackage

// ===== hw/rtl/ppp_front.sv =====
// ----------------------------------------------------------------------------
// ppp_front
// View-space sum, focal multiply, magnitude and quotient range check,
// four register stages with per-stage valid and bubble collapsing.
// ----------------------------------------------------------------------------
module ppp_front #(
    parameter int QUOT_W = ppp_pkg::DEF_QUOT_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ppp_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ppp_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ppp_pkg::div_req_t               out_req
);

    function automatic logic signed [ppp_pkg::VIEW_W-1:0] widen(
        input logic [ppp_pkg::COORD_W-1:0] v
    );
        widen = $signed({{(ppp_pkg::VIEW_W - ppp_pkg::COORD_W){v[ppp_pkg::COORD_W-1]}}, v});
    endfunction

    // stage 1: view-space point
    logic                                 v1_reg;
    logic                                 last1_reg;
    logic signed [ppp_pkg::VIEW_W-1:0]    vx_reg, vy_reg, vz_reg;
    logic signed [ppp_pkg::VIEW_W-1:0]    vx_next, vy_next, vz_next;

    // stage 2: focal products
    logic                                 v2_reg;
    logic                                 last2_reg;
    logic                                 zpos2_reg;
    logic [ppp_pkg::DEPTH_W-1:0]          depth2_reg;
    logic signed [ppp_pkg::PROD_W-1:0]    prod_x_reg, prod_y_reg;
    logic signed [ppp_pkg::PROD_W-1:0]    prod_x_next, prod_y_next;

    // stage 3: magnitudes
    logic                                 v3_reg;
    logic                                 last3_reg;
    logic                                 zpos3_reg;
    logic                                 sign_x3_reg, sign_y3_reg;
    logic [ppp_pkg::DEPTH_W-1:0]          depth3_reg;
    logic [ppp_pkg::MAG_W-1:0]            mag_x3_reg, mag_y3_reg;
    logic [ppp_pkg::MAG_W-1:0]            mag_x3_next, mag_y3_next;

    // stage 4: range check
    logic                                 v4_reg;
    ppp_pkg::div_req_t                    req_reg;
    ppp_pkg::div_req_t                    req_next;

    logic r1, r2, r3, r4;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign vx_next = widen(in_data[ppp_pkg::COORD_W-1:0])
                   + widen(cfg.model_x) - widen(cfg.camera_x);
    assign vy_next = widen(in_data[2*ppp_pkg::COORD_W-1:ppp_pkg::COORD_W])
                   + widen(cfg.model_y) - widen(cfg.camera_y);
    assign vz_next = widen(in_data[3*ppp_pkg::COORD_W-1:2*ppp_pkg::COORD_W])
                   + widen(cfg.model_z) - widen(cfg.camera_z);

    assign prod_x_next = $signed({1'b0, cfg.focal}) * vx_reg;
    assign prod_y_next = $signed({1'b0, cfg.focal}) * vy_reg;

    assign mag_x3_next = prod_x_reg[ppp_pkg::PROD_W-1]
                       ? ppp_pkg::MAG_W'(-prod_x_reg) : ppp_pkg::MAG_W'(prod_x_reg);
    assign mag_y3_next = prod_y_reg[ppp_pkg::PROD_W-1]
                       ? ppp_pkg::MAG_W'(-prod_y_reg) : ppp_pkg::MAG_W'(prod_y_reg);

    always_comb begin
        req_next              = '0;
        req_next.flags.last   = last3_reg;
        req_next.flags.zpos   = zpos3_reg;
        req_next.flags.sign_x = sign_x3_reg;
        req_next.flags.sign_y = sign_y3_reg;
        req_next.flags.ovf_x  = (mag_x3_reg >> QUOT_W) >= ppp_pkg::MAG_W'(depth3_reg);
        req_next.flags.ovf_y  = (mag_y3_reg >> QUOT_W) >= ppp_pkg::MAG_W'(depth3_reg);
        req_next.depth        = depth3_reg;
        req_next.mag_x        = mag_x3_reg;
        req_next.mag_y        = mag_y3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            vz_reg    <= vz_next;
            last1_reg <= in_last;
        end
        if (r2 && v1_reg) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            zpos2_reg  <= vz_reg > 0;
            depth2_reg <= vz_reg[ppp_pkg::DEPTH_W-1:0];
            last2_reg  <= last1_reg;
        end
        if (r3 && v2_reg) begin
            mag_x3_reg  <= mag_x3_next;
            mag_y3_reg  <= mag_y3_next;
            sign_x3_reg <= prod_x_reg[ppp_pkg::PROD_W-1];
            sign_y3_reg <= prod_y_reg[ppp_pkg::PROD_W-1];
            zpos3_reg   <= zpos2_reg;
            depth3_reg  <= depth2_reg;
            last3_reg   <= last2_reg;
        end
        if (r4 && v3_reg) begin
            req_reg <= req_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_req   = req_reg;

endmodule

// ===== hw/rtl/ppp_div.sv =====
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider for both screen axes: one quotient bit per
// stage, most significant first, over a shared depth divisor.
// ----------------------------------------------------------------------------
module ppp_div #(
    parameter int QUOT_W = ppp_pkg::DEF_QUOT_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ppp_pkg::div_req_t    in_req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ppp_pkg::flags_t      out_flags,
    output logic [QUOT_W-1:0]    out_quot_x,
    output logic [QUOT_W-1:0]    out_quot_y
);

    localparam int REM_W = ((ppp_pkg::MAG_W > ppp_pkg::DEPTH_W + QUOT_W)
                            ? ppp_pkg::MAG_W : ppp_pkg::DEPTH_W + QUOT_W) + 1;

    logic [QUOT_W-1:0]              vld_reg;
    logic [QUOT_W:0]                rdy;
    ppp_pkg::flags_t                flags_reg  [QUOT_W];
    logic [ppp_pkg::DEPTH_W-1:0]    depth_reg  [QUOT_W];
    logic [ppp_pkg::MAG_W-1:0]      rem_x_reg  [QUOT_W];
    logic [ppp_pkg::MAG_W-1:0]      rem_y_reg  [QUOT_W];
    logic [QUOT_W-1:0]              quot_x_reg [QUOT_W];
    logic [QUOT_W-1:0]              quot_y_reg [QUOT_W];

    logic                           src_v      [QUOT_W];
    ppp_pkg::flags_t                src_flags  [QUOT_W];
    logic [ppp_pkg::DEPTH_W-1:0]    src_depth  [QUOT_W];
    logic [ppp_pkg::MAG_W-1:0]      rem_x_next [QUOT_W];
    logic [ppp_pkg::MAG_W-1:0]      rem_y_next [QUOT_W];
    logic [QUOT_W-1:0]              quot_x_next[QUOT_W];
    logic [QUOT_W-1:0]              quot_y_next[QUOT_W];

    always_comb begin
        rdy[QUOT_W] = out_ready;
        for (int k = QUOT_W - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        logic [ppp_pkg::MAG_W-1:0] rx, ry;
        logic [QUOT_W-1:0]         qx, qy;
        logic [REM_W-1:0]          dvs, trial_x, trial_y;
        for (int k = 0; k < QUOT_W; k++) begin
            if (k == 0) begin
                src_v[k]     = in_valid;
                src_flags[k] = in_req.flags;
                src_depth[k] = in_req.depth;
                rx           = in_req.mag_x;
                ry           = in_req.mag_y;
                qx           = '0;
                qy           = '0;
            end else begin
                src_v[k]     = vld_reg[k-1];
                src_flags[k] = flags_reg[k-1];
                src_depth[k] = depth_reg[k-1];
                rx           = rem_x_reg[k-1];
                ry           = rem_y_reg[k-1];
                qx           = quot_x_reg[k-1];
                qy           = quot_y_reg[k-1];
            end
            dvs     = REM_W'(src_depth[k]) << (QUOT_W - 1 - k);
            trial_x = REM_W'(rx) - dvs;
            trial_y = REM_W'(ry) - dvs;
            rem_x_next[k]  = trial_x[REM_W-1] ? rx : ppp_pkg::MAG_W'(trial_x);
            rem_y_next[k]  = trial_y[REM_W-1] ? ry : ppp_pkg::MAG_W'(trial_y);
            quot_x_next[k] = qx;
            quot_y_next[k] = qy;
            quot_x_next[k][QUOT_W-1-k] = !trial_x[REM_W-1];
            quot_y_next[k][QUOT_W-1-k] = !trial_y[REM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < QUOT_W; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= src_v[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QUOT_W; k++) begin
            if (rdy[k] && src_v[k]) begin
                flags_reg[k]  <= src_flags[k];
                depth_reg[k]  <= src_depth[k];
                rem_x_reg[k]  <= rem_x_next[k];
                rem_y_reg[k]  <= rem_y_next[k];
                quot_x_reg[k] <= quot_x_next[k];
                quot_y_reg[k] <= quot_y_next[k];
            end
        end
    end

    assign out_valid  = vld_reg[QUOT_W-1];
    assign out_flags  = flags_reg[QUOT_W-1];
    assign out_quot_x = quot_x_reg[QUOT_W-1];
    assign out_quot_y = quot_y_reg[QUOT_W-1];

endmodule

// ===== hw/rtl/ppp_back.sv =====
// ----------------------------------------------------------------------------
// ppp_back
// Signed screen position, on-screen test and framebuffer address, ending in
// the output register of the result channel.
// ----------------------------------------------------------------------------
module ppp_back #(
    parameter int SCREEN_WIDTH  = ppp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ppp_pkg::DEF_SCREEN_HEIGHT,
    parameter int QUOT_W        = ppp_pkg::DEF_QUOT_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ppp_pkg::flags_t               in_flags,
    input  logic [QUOT_W-1:0]             in_quot_x,
    input  logic [QUOT_W-1:0]             in_quot_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_visible,
    output logic [ppp_pkg::PIX_W-1:0]     out_pixel_x,
    output logic [ppp_pkg::PIX_W-1:0]     out_pixel_y,
    output logic [ppp_pkg::ADDR_W-1:0]    out_address,
    output logic                          out_last
);

    localparam int SQ_W   = QUOT_W + 2;
    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = $clog2(SCREEN_HEIGHT);
    localparam int FULL_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

    localparam logic signed [SQ_W-1:0]   HALF_W = SQ_W'(SCREEN_WIDTH / 2);
    localparam logic signed [SQ_W-1:0]   HALF_H = SQ_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [SQ_W-1:0]   LIM_W  = SQ_W'(SCREEN_WIDTH);
    localparam logic signed [SQ_W-1:0]   LIM_H  = SQ_W'(SCREEN_HEIGHT);
    localparam logic [FULL_W-1:0]        ROW_W  = FULL_W'(SCREEN_WIDTH);

    logic                     vp_reg, vq_reg;
    logic                     rp, rq;

    logic signed [SQ_W-1:0]   qx_s, qy_s, pos_x, pos_y;
    logic                     vis_next;
    logic                     vis_p_reg, last_p_reg;
    logic [XW-1:0]            px_reg, px_next;
    logic [YW-1:0]            py_reg, py_next;

    logic [FULL_W-1:0]        full_addr;
    logic                     vis_q_reg, last_q_reg;
    logic [ppp_pkg::PIX_W-1:0]  pixel_x_reg, pixel_y_reg;
    logic [ppp_pkg::ADDR_W-1:0] address_reg;

    assign rq       = !vq_reg || out_ready;
    assign rp       = !vp_reg || rq;
    assign in_ready = rp;

    always_comb begin
        qx_s = in_flags.sign_x ? -$signed({2'b00, in_quot_x}) : $signed({2'b00, in_quot_x});
        qy_s = in_flags.sign_y ? -$signed({2'b00, in_quot_y}) : $signed({2'b00, in_quot_y});
        pos_x = HALF_W + qx_s;
        pos_y = HALF_H - qy_s;
        vis_next = in_flags.zpos && !in_flags.ovf_x && !in_flags.ovf_y
                && !pos_x[SQ_W-1] && (pos_x < LIM_W)
                && !pos_y[SQ_W-1] && (pos_y < LIM_H);
        px_next = vis_next ? pos_x[XW-1:0] : '0;
        py_next = vis_next ? pos_y[YW-1:0] : '0;
    end

    assign full_addr = FULL_W'(py_reg) * ROW_W + FULL_W'(px_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
        end else begin
            if (rp) begin
                vp_reg <= in_valid;
            end
            if (rq) begin
                vq_reg <= vp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rp && in_valid) begin
            vis_p_reg  <= vis_next;
            last_p_reg <= in_flags.last;
            px_reg     <= px_next;
            py_reg     <= py_next;
        end
        if (rq && vp_reg) begin
            vis_q_reg   <= vis_p_reg;
            last_q_reg  <= last_p_reg;
            pixel_x_reg <= ppp_pkg::PIX_W'(px_reg);
            pixel_y_reg <= ppp_pkg::PIX_W'(py_reg);
            address_reg <= ppp_pkg::ADDR_W'(full_addr);
        end
    end

    assign out_valid   = vq_reg;
    assign out_visible = vis_q_reg;
    assign out_pixel_x = pixel_x_reg;
    assign out_pixel_y = pixel_y_reg;
    assign out_address = address_reg;
    assign out_last    = last_q_reg;

endmodule

// ===== hw/rtl/perspective_point_projection.sv =====
// ----------------------------------------------------------------------------
// perspective_point_projection
// Pinhole projection of Q16.16 vertices onto a framebuffer.
// ----------------------------------------------------------------------------
// Takes one vertex per cycle while the output is not stalled and returns one
// result per vertex, in order, after 6 + QUOT_W register stages, where QUOT_W
// is one more than the base-two log of the larger screen dimension, rounded up.
// The latency is set by the restoring divider, which resolves one quotient bit
// per stage for both axes; the sum, the focal multiply, the magnitude and the
// range check take four stages ahead of it and the screen position and address
// two after. Each stage holds its own valid bit, so empty stages fill while the
// output is stalled. A point with view depth of zero or less, or one that lands
// off screen, comes out with the visible flag low and zero coordinates. Write
// the configuration registers only while no vertex is in flight.
// ----------------------------------------------------------------------------
module perspective_point_projection #(
    parameter int SCREEN_WIDTH  = ppp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ppp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppp_pkg::PADDR_W-1:0]      paddr,
    input  logic [ppp_pkg::PDATA_W-1:0]      pwdata,
    output logic [ppp_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
    input  logic [ppp_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x [9:0], pixel_y [19:10], pixel_address [38:20], zero [39]
    output logic [ppp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // visible [0]
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int QUOT_W =
        $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT) + 1;

    ppp_pkg::cfg_t      cfg_reg, cfg_next;
    ppp_pkg::reg_idx_t  reg_idx;
    logic               cfg_wr;

    logic               fd_valid, fd_ready;
    ppp_pkg::div_req_t  fd_req;
    logic               db_valid, db_ready;
    ppp_pkg::flags_t    db_flags;
    logic [QUOT_W-1:0]  db_quot_x, db_quot_y;

    logic                        visible;
    logic [ppp_pkg::PIX_W-1:0]   pixel_x, pixel_y;
    logic [ppp_pkg::ADDR_W-1:0]  pixel_address;

    assign pready  = 1'b1;
    assign reg_idx = ppp_pkg::reg_idx_t'(paddr[ppp_pkg::PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                ppp_pkg::REG_MODEL_X:  cfg_next.model_x  = pwdata;
                ppp_pkg::REG_MODEL_Y:  cfg_next.model_y  = pwdata;
                ppp_pkg::REG_MODEL_Z:  cfg_next.model_z  = pwdata;
                ppp_pkg::REG_CAMERA_X: cfg_next.camera_x = pwdata;
                ppp_pkg::REG_CAMERA_Y: cfg_next.camera_y = pwdata;
                ppp_pkg::REG_CAMERA_Z: cfg_next.camera_z = pwdata;
                ppp_pkg::REG_FOCAL:    cfg_next.focal    = pwdata[ppp_pkg::FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ppp_pkg::REG_MODEL_X:  prdata = cfg_reg.model_x;
            ppp_pkg::REG_MODEL_Y:  prdata = cfg_reg.model_y;
            ppp_pkg::REG_MODEL_Z:  prdata = cfg_reg.model_z;
            ppp_pkg::REG_CAMERA_X: prdata = cfg_reg.camera_x;
            ppp_pkg::REG_CAMERA_Y: prdata = cfg_reg.camera_y;
            ppp_pkg::REG_CAMERA_Z: prdata = cfg_reg.camera_z;
            ppp_pkg::REG_FOCAL:    prdata = ppp_pkg::PDATA_W'(cfg_reg.focal);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ppp_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ppp_front #(
        .QUOT_W   (QUOT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (fd_valid),
        .out_ready (fd_ready),
        .out_req   (fd_req)
    );

    ppp_div #(
        .QUOT_W   (QUOT_W)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fd_valid),
        .in_ready   (fd_ready),
        .in_req     (fd_req),
        .out_valid  (db_valid),
        .out_ready  (db_ready),
        .out_flags  (db_flags),
        .out_quot_x (db_quot_x),
        .out_quot_y (db_quot_y)
    );

    ppp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .QUOT_W        (QUOT_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (db_valid),
        .in_ready    (db_ready),
        .in_flags    (db_flags),
        .in_quot_x   (db_quot_x),
        .in_quot_y   (db_quot_y),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_visible (visible),
        .out_pixel_x (pixel_x),
        .out_pixel_y (pixel_y),
        .out_address (pixel_address),
        .out_last    (m_tlast)
    );

    assign m_tdata = {1'b0, pixel_address, pixel_y, pixel_x};
    assign m_tuser = visible;

endmodule

// ===== hw/rtl/ppp_checker.sv =====
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks on the result channel of the projection block.
// ----------------------------------------------------------------------------
module ppp_checker #(
    parameter int SCREEN_WIDTH  = ppp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ppp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ppp_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    input  logic                             m_tlast
);

    // hold a stalled request
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("hidden point carries nonzero position");

    a_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (32'(m_tdata[9:0]) < SCREEN_WIDTH)
                             && (32'(m_tdata[19:10]) < SCREEN_HEIGHT))
        else $error("visible point outside the screen");

endmodule

bind perspective_point_projection ppp_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ppp_checker (.*);

// ===== test/perspective_point_projection_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_point_projection_tb
// Self-checking bench for the pinhole point projection pipeline.
// ----------------------------------------------------------------------------
// Streams vertices through the block and checks every projected pixel against
// a local model of the view transform, the divide and the screen bounds. A
// table of directed vertices covers the screen edges and corners, points
// behind the camera and overflowing quotients. Random vertices follow, most
// of them aimed at or near the screen. The position registers and the focal
// length are reloaded between phases: reset values, moderate values, the
// extremes, zero focal length and an unmapped register address. Both stream
// sides stall at random, except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
module perspective_point_projection_tb;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 24;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;
    localparam int          HALF_W      = ppp_pkg::DEF_SCREEN_WIDTH / 2;
    localparam int          HALF_H      = ppp_pkg::DEF_SCREEN_HEIGHT / 2;

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sd65536;
    localparam logic signed [31:0] EDGE_Z = 32'sd58982400;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } vertex_t;

    typedef struct packed {
        logic        visible;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [18:0] addr;
        logic        last;
    } pixel_t;

    typedef struct {
        vertex_t v;
        bit      known;
        pixel_t  want;
    } probe_t;

    localparam int N_PROBES = 20;

    probe_t probes [N_PROBES] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{32'sd0, 32'sd0, ONE, 1'b1}, 1'b1, '{1'b1, 10'd400, 10'd300, 19'd240400, 1'b1}},
        '{'{32'sd0, 32'sd0, -32'sd1, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{32'sd0, 32'sd0, MINV, 1'b1}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b1}},
        '{'{MAXV, MAXV, MAXV, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{MINV, MINV, 32'sd1, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{32'sd0, 32'sd0, MAXV, 1'b0}, 1'b1, '{1'b1, 10'd400, 10'd300, 19'd240400, 1'b0}},
        '{'{-32'sd26214400, 32'sd0, EDGE_Z, 1'b0}, 1'b1,
          '{1'b1, 10'd0, 10'd300, 19'd240000, 1'b0}},
        '{'{32'sd26148864, 32'sd0, EDGE_Z, 1'b0}, 1'b1,
          '{1'b1, 10'd799, 10'd300, 19'd240799, 1'b0}},
        '{'{32'sd26214400, 32'sd0, EDGE_Z, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{-32'sd26279936, 32'sd0, EDGE_Z, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{32'sd0, 32'sd19660800, EDGE_Z, 1'b0}, 1'b1,
          '{1'b1, 10'd400, 10'd0, 19'd400, 1'b0}},
        '{'{32'sd0, -32'sd19595264, EDGE_Z, 1'b0}, 1'b1,
          '{1'b1, 10'd400, 10'd599, 19'd479600, 1'b0}},
        '{'{32'sd0, -32'sd19660800, EDGE_Z, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{32'sd0, 32'sd19726336, EDGE_Z, 1'b0}, 1'b1, '{1'b0, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{-32'sd26214400, 32'sd19660800, EDGE_Z, 1'b0}, 1'b1,
          '{1'b1, 10'd0, 10'd0, 19'd0, 1'b0}},
        '{'{32'sd26148864, -32'sd19595264, EDGE_Z, 1'b1}, 1'b1,
          '{1'b1, 10'd799, 10'd599, 19'd479999, 1'b1}},
        '{'{32'sd65535, -32'sd65535, EDGE_Z, 1'b0}, 1'b0, '0},
        '{'{32'sd12345678, -32'sd7654321, 32'sd99999999, 1'b1}, 1'b0, '0},
        '{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF, 1'b0}, 1'b0, '0}
    };

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [ppp_pkg::PADDR_W-1:0]     paddr    = '0;
    logic [ppp_pkg::PDATA_W-1:0]     pwdata   = '0;
    logic [ppp_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
    logic [ppp_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // pixel_x [9:0], pixel_y [19:10], pixel_address [38:20], zero [39]
    logic [ppp_pkg::OUT_DATA_W-1:0]  m_tdata;
    // visible [0]
    logic                            m_tuser;
    logic                            m_tlast;

    logic signed [31:0] model_pos  [3] = '{32'sd0, 32'sd0, -32'sd655360};
    logic signed [31:0] camera_pos [3] = '{32'sd0, 32'sd0, -32'sd655360};
    logic [11:0]        focal          = 12'd900;

    pixel_t projected_q [$];
    bit     steady       = 1'b0;
    int     error_count  = 0;
    int     sent_count   = 0;
    int     pixel_count  = 0;
    int     on_screen    = 0;
    int     phase_count  = 0;

    perspective_point_projection u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic pixel_t project_vertex(vertex_t v);
        pixel_t  p;
        longint  vx, vy, vz, qx, qy, col, row;
        p      = '0;
        p.last = v.last;
        vx = longint'(v.x) + longint'(model_pos[0]) - longint'(camera_pos[0]);
        vy = longint'(v.y) + longint'(model_pos[1]) - longint'(camera_pos[1]);
        vz = longint'(v.z) + longint'(model_pos[2]) - longint'(camera_pos[2]);
        if (vz > 0) begin
            qx  = (longint'(focal) * vx) / vz;
            qy  = (longint'(focal) * vy) / vz;
            col = HALF_W + qx;
            row = HALF_H - qy;
            if (col >= 0 && col < ppp_pkg::DEF_SCREEN_WIDTH
                    && row >= 0 && row < ppp_pkg::DEF_SCREEN_HEIGHT) begin
                p.visible = 1'b1;
                p.px      = col[9:0];
                p.py      = row[9:0];
                p.addr    = 19'(row * ppp_pkg::DEF_SCREEN_WIDTH + col);
            end
        end
        return p;
    endfunction

    // aim most vertices at a random spot on or just past the screen
    function automatic vertex_t aim_vertex();
        vertex_t v;
        longint  lens, depth, col, row, wx, wy;
        v.last = ($urandom_range(7) == 0);
        if ($urandom_range(99) < 15) begin
            v.x = $urandom;
            v.y = $urandom;
            v.z = $urandom;
            return v;
        end
        lens  = (focal == 0) ? 1 : longint'(focal);
        depth = longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
        col   = longint'($urandom_range(0, 840)) - 420;
        row   = longint'($urandom_range(0, 640)) - 320;
        wx    = col * depth / lens + longint'($urandom_range(0, int'(depth / lens)));
        wy    = row * depth / lens - longint'($urandom_range(0, int'(depth / lens)));
        v.x   = 32'(wx - longint'(model_pos[0]) + longint'(camera_pos[0]));
        v.y   = 32'(wy - longint'(model_pos[1]) + longint'(camera_pos[1]));
        v.z   = 32'(depth - longint'(model_pos[2]) + longint'(camera_pos[2]));
        return v;
    endfunction

    function automatic logic [31:0] near_origin();
        return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = pready;
            @(posedge aclk);
        end while (!rdy);
        case (idx)
            ppp_pkg::REG_MODEL_X:  model_pos[0]  = value;
            ppp_pkg::REG_MODEL_Y:  model_pos[1]  = value;
            ppp_pkg::REG_MODEL_Z:  model_pos[2]  = value;
            ppp_pkg::REG_CAMERA_X: camera_pos[0] = value;
            ppp_pkg::REG_CAMERA_Y: camera_pos[1] = value;
            ppp_pkg::REG_CAMERA_Z: camera_pos[2] = value;
            ppp_pkg::REG_FOCAL:    focal         = value[11:0];
            default:      ;
        endcase
    endtask

    task automatic load_config(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                               logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [11:0] f);
        write_reg(ppp_pkg::REG_MODEL_X, mx);
        write_reg(ppp_pkg::REG_MODEL_Y, my);
        write_reg(ppp_pkg::REG_MODEL_Z, mz);
        write_reg(ppp_pkg::REG_CAMERA_X, cx);
        write_reg(ppp_pkg::REG_CAMERA_Y, cy);
        write_reg(ppp_pkg::REG_CAMERA_Z, cz);
        write_reg(ppp_pkg::REG_FOCAL, {20'd0, f});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        phase_count++;
    endtask

    task automatic send_vertex(vertex_t v, pixel_t want);
        logic rdy;
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v.z, v.y, v.x};
        s_tlast  <= v.last;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        projected_q.push_back(want);
        sent_count++;
    endtask

    // hold the sender until every pending pixel has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        while (projected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_random(int count);
        vertex_t v;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            v = aim_vertex();
            send_vertex(v, project_vertex(v));
        end
        drain();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // the request completes at the next rising edge; check it now
    always @(negedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.visible = m_tuser;
            got.px      = m_tdata[9:0];
            got.py      = m_tdata[19:10];
            got.addr    = m_tdata[38:20];
            got.last    = m_tlast;
            pixel_count++;
            if (got.visible) on_screen++;
            if (projected_q.size() == 0) begin
                $error("pixel request with no vertex pending");
                error_count++;
            end else begin
                want = projected_q.pop_front();
                check_field("visible", want.visible, got.visible);
                check_field("pixel_x", want.px, got.px);
                check_field("pixel_y", want.py, got.py);
                check_field("pixel_address", want.addr, got.addr);
                check_field("last_pixel", want.last, got.last);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i])
            send_vertex(probes[i].v,
                        probes[i].known ? probes[i].want : project_vertex(probes[i].v));
        run_random(250);

        load_config(near_origin(), near_origin(), near_origin(),
                    near_origin(), near_origin(), near_origin(),
                    12'($urandom_range(1, 4095)));
        steady = 1'b1;
        run_random(250);
        steady = 1'b0;

        load_config(MAXV, MAXV, MAXV, MINV, MINV, MINV, 12'd4095);
        run_random(150);

        load_config(MINV, MINV, MINV, MAXV, MAXV, MAXV, 12'd1);
        run_random(80);

        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 12'd0);
        write_reg(REG_UNUSED, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        run_random(150);

        load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 12'd1);
        run_random(150);

        load_config(near_origin(), near_origin(), near_origin(),
                    near_origin(), near_origin(), near_origin(),
                    12'($urandom_range(1, 4095)));
        run_random(300);

        $display("Projected %0d vertices over %0d register settings plus reset values,",
                 sent_count, phase_count);
        $display("%0d pixels returned, %0d of them on screen", pixel_count, on_screen);
        if (error_count == 0 && projected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
